/* rtl/range_scan_temporal_filter_defines.svh */
// assertion macros for the range scan temporal filter
`ifndef RANGE_SCAN_TEMPORAL_FILTER_DEFINES_SVH
`define RANGE_SCAN_TEMPORAL_FILTER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RSTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is applied
`define RSTF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rstf_pkg.sv */
// shared widths, register indexes and reset values for the range scan temporal filter
package rstf_pkg;

    // field widths
    localparam int DIST_W  = 17;
    localparam int ANGLE_W = 12;
    localparam int INDEX_W = 10;
    localparam int START_W = 10;
    localparam int LIMIT_W = 16;
    localparam int CNT_W   = 11;

    // stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_RANGE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFFERENCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE    = 2'd3;

    // register reset values
    localparam logic                       FILTER_ENABLE_RST = 1'b1;
    localparam logic [LIMIT_W-1:0]         NEAR_RANGE_RST    = 16'd500;
    localparam logic [LIMIT_W-1:0]         MAX_DIFF_RST      = 16'd100;
    localparam logic signed [START_W-1:0]  START_ANGLE_RST   = -10'sd141;

    // counter limits
    localparam logic [CNT_W-1:0]   CNT_MAX   = 11'd2047;
    localparam logic [INDEX_W-1:0] INDEX_MAX = 10'd1023;

    // default depth of the previous scan store
    localparam int SCAN_DEPTH_DEF = 1024;

endpackage

/* rtl/range_scan_temporal_filter.sv */
// range scan temporal filter: glint rejection against the previous scan's readings
// a reading passes through the read stage register and then the output register
// throughput: one reading per cycle; the previous scan store is read at accept and
// written back as the reading moves to the output register, with forwarding when the
// next reading revisits that index; the input stalls only while both stages are full
// the store takes no clearing pass and is usable at once after reset; entries are
// undefined until the first scan has written them
// reset clears the beam counter and the pipeline, sets the first scan flag and loads the register reset values
module range_scan_temporal_filter #(
    parameter int SCAN_DEPTH = rstf_pkg::SCAN_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_wr_en,
    input  logic [rstf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rstf_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input readings
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rstf_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [16:0] distance
    input  logic                             s_axis_tlast,  // scan_end
    // filtered readings
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rstf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [16:0] filtered_distance,
                                                            // [28:17] beam_angle,
                                                            // [38:29] beam_index
    output logic                             m_axis_tlast   // last
);

    import rstf_pkg::*;

    `include "range_scan_temporal_filter_defines.svh"

    localparam int ADDR_W = $clog2(SCAN_DEPTH);

    // configuration registers
    logic                        filter_enable_reg;
    logic [LIMIT_W-1:0]          near_range_reg;
    logic [LIMIT_W-1:0]          max_diff_reg;
    logic signed [START_W-1:0]   start_angle_reg;

    // scan tracking
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        first_scan_reg, first_scan_next;

    // read stage
    logic                        s1_valid_reg, s1_valid_next;
    logic signed [DIST_W-1:0]    s1_dist_reg;
    logic                        s1_last_reg;
    logic                        s1_store_reg;
    logic [ADDR_W-1:0]           s1_addr_reg;
    logic                        s1_first_reg;
    logic signed [ANGLE_W-1:0]   s1_angle_reg;
    logic [INDEX_W-1:0]          s1_index_reg;
    logic                        fwd_hit_reg;
    logic signed [DIST_W-1:0]    fwd_data_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic signed [DIST_W-1:0]    out_dist_reg;
    logic signed [ANGLE_W-1:0]   out_angle_reg;
    logic [INDEX_W-1:0]          out_index_reg;
    logic                        out_last_reg;

    // previous scan store
    logic signed [DIST_W-1:0]    mem [SCAN_DEPTH];
    logic signed [DIST_W-1:0]    rd_data_reg;

    // combinational signals
    logic                        in_xfer;
    logic                        s1_adv;
    logic                        mem_wr;
    logic signed [DIST_W-1:0]    in_dist;
    logic                        in_store;
    logic [ADDR_W-1:0]           in_addr;
    logic [INDEX_W-1:0]          in_index;
    logic signed [ANGLE_W-1:0]   in_angle;
    logic                        in_fwd_hit;
    logic signed [DIST_W-1:0]    prev_dist;
    logic signed [DIST_W:0]      diff;
    logic [DIST_W:0]             abs_diff;
    logic                        is_near;
    logic                        is_far;
    logic                        reject;
    logic signed [DIST_W-1:0]    result_dist;

    // handshake
    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign mem_wr        = s1_valid_reg && s1_adv && s1_store_reg;

    // input decode, index and angle
    always_comb
    begin
        in_dist    = s_axis_tdata[DIST_W-1:0];
        in_store   = (32'(cnt_reg) < 32'(SCAN_DEPTH)) && (cnt_reg != CNT_MAX);
        in_addr    = ADDR_W'(cnt_reg);
        in_index   = (cnt_reg > CNT_W'(INDEX_MAX)) ? INDEX_MAX : cnt_reg[INDEX_W-1:0];
        in_angle   = ANGLE_W'(start_angle_reg) + $signed({2'b00, in_index});
        in_fwd_hit = mem_wr && in_store && (s1_addr_reg == in_addr);
    end

    // counter and first scan flag
    always_comb
    begin
        cnt_next        = cnt_reg;
        first_scan_next = first_scan_reg;
        if (in_xfer)
        begin
            if (s_axis_tlast)
            begin
                cnt_next        = '0;
                first_scan_next = 1'b0;
            end
            else if (cnt_reg != CNT_MAX)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    // rejection rule, no return counts as below any limit
    always_comb
    begin
        prev_dist   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        diff        = {prev_dist[DIST_W-1], prev_dist} - {s1_dist_reg[DIST_W-1], s1_dist_reg};
        abs_diff    = diff[DIST_W] ? (DIST_W+1)'(-diff) : diff;
        is_near     = $signed({s1_dist_reg[DIST_W-1], s1_dist_reg})
                      < $signed({2'b00, near_range_reg});
        is_far      = abs_diff > {2'b00, max_diff_reg};
        reject      = filter_enable_reg && !s1_first_reg && s1_store_reg && is_near && is_far;
        result_dist = reject ? -DIST_W'(1) : s1_dist_reg;
    end

    // valid flags
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= FILTER_ENABLE_RST;
            near_range_reg    <= NEAR_RANGE_RST;
            max_diff_reg      <= MAX_DIFF_RST;
            start_angle_reg   <= START_ANGLE_RST;
            cnt_reg           <= '0;
            first_scan_reg    <= 1'b1;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FILTER_ENABLE:  filter_enable_reg <= cfg_data[0];
                    REG_NEAR_RANGE:     near_range_reg    <= cfg_data[LIMIT_W-1:0];
                    REG_MAX_DIFFERENCE: max_diff_reg      <= cfg_data[LIMIT_W-1:0];
                    REG_START_ANGLE:    start_angle_reg   <= cfg_data[START_W-1:0];
                    default:            ;
                endcase
            end
            cnt_reg        <= cnt_next;
            first_scan_reg <= first_scan_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_dist_reg  <= in_dist;
            s1_last_reg  <= s_axis_tlast;
            s1_store_reg <= in_store;
            s1_addr_reg  <= in_addr;
            s1_first_reg <= first_scan_reg;
            s1_angle_reg <= in_angle;
            s1_index_reg <= in_index;
            fwd_hit_reg  <= in_fwd_hit;
            fwd_data_reg <= s1_dist_reg;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_dist_reg  <= result_dist;
            out_angle_reg <= s1_angle_reg;
            out_index_reg <= s1_index_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    // previous scan store: read at accept, raw reading written back as it leaves
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[s1_addr_reg] <= s1_dist_reg;
        end
        if (in_xfer && in_store)
        begin
            rd_data_reg <= mem[in_addr];
        end
    end

    // master side
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_index_reg, out_angle_reg, out_dist_reg};
    assign m_axis_tlast  = out_last_reg;

    // checks
    `RSTF_ASSERT(a_fwd_needs_item, fwd_hit_reg && s1_valid_reg |-> s1_store_reg,
        "forwarded store data on an item outside the store")
    `RSTF_ASSERT(a_scan_end_restart, in_xfer && s_axis_tlast |=> cnt_reg == '0 && !first_scan_reg,
        "beam counter did not restart after the last reading of a scan")
    `RSTF_ASSERT(a_ready_when_drained, !out_valid_reg |-> s_axis_tready,
        "input stalled while the output register is empty")
    `RSTF_ASSERT_ALWAYS(a_no_write_in_reset, !rst_n |-> !mem_wr,
        "store written during reset")

endmodule

/* verif/range_scan_temporal_filter_test.sv */
`timescale 1ns / 100ps
// testbench for the range scan temporal filter: streams scans and checks each filtered beam
module range_scan_temporal_filter_test;
    import rstf_pkg::*;

    localparam int STORE_DEPTH     = SCAN_DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 4;

    // one filtered beam as it leaves the block
    typedef struct packed {
        logic signed [DIST_W-1:0]  range_mm;
        logic signed [ANGLE_W-1:0] angle;
        logic [INDEX_W-1:0]        index;
        logic                      last;
    } beam_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FILTER_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [16:0] distance
    logic                  s_axis_tlast = 1'b0; // scan_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [16:0] filtered_distance, [28:17] beam_angle,
                                                // [38:29] beam_index
    logic                  m_axis_tlast;        // last

    // predictor copy of the block state and registers
    logic signed [DIST_W-1:0]  prev_scan_range [STORE_DEPTH];
    logic [CNT_W-1:0]          beam_count = '0;
    logic                      in_first_scan = 1'b1;
    logic                      filter_on = FILTER_ENABLE_RST;
    logic [LIMIT_W-1:0]        near_limit = NEAR_RANGE_RST;
    logic [LIMIT_W-1:0]        max_change = MAX_DIFF_RST;
    logic signed [START_W-1:0] first_angle = START_ANGLE_RST;

    beam_t pending_beams[$];
    int    mismatch_count = 0;
    int    sender_idle_pct = 0;
    int    receiver_stall_pct = 0;
    logic  hold_off_toggle = 1'b0;
    logic  hold_off_seen = 1'b0;
    int    hold_off_left = 0;

    range_scan_temporal_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // filtered beam for one reading, advancing the predictor state
    function automatic beam_t filter_reading(logic signed [DIST_W-1:0] reading,
                                             logic scan_end);
        beam_t expected_beam;
        int    reading_mm;
        int    stored_mm;
        int    change;
        int    index_val;
        int    angle_base;
        int    limit;
        int    allowed;
        reading_mm = reading;
        index_val  = (beam_count > INDEX_MAX) ? INDEX_MAX : beam_count;
        angle_base = first_angle;
        limit      = near_limit;
        allowed    = max_change;
        expected_beam.range_mm = reading;
        expected_beam.angle    = ANGLE_W'(angle_base + index_val);
        expected_beam.index    = INDEX_W'(index_val);
        expected_beam.last     = scan_end;
        // glint rejection against the previous scan, only inside the store
        if (beam_count < STORE_DEPTH && beam_count != CNT_MAX)
        begin
            stored_mm = prev_scan_range[beam_count];
            change = stored_mm - reading_mm;
            if (change < 0)
                change = -change;
            if (filter_on && !in_first_scan && reading_mm < limit && change > allowed)
                expected_beam.range_mm = '1;
            prev_scan_range[beam_count] = reading;
        end
        // beam counter saturates, clears on scan end
        if (scan_end)
        begin
            beam_count    = '0;
            in_first_scan = 1'b0;
        end
        else if (beam_count != CNT_MAX)
        begin
            beam_count = beam_count + CNT_W'(1);
        end
        return expected_beam;
    endfunction

    // random range, biased toward the rejection thresholds at the next beam
    function automatic logic signed [DIST_W-1:0] pick_range();
        int stored_mm;
        int offset;
        int pick;
        stored_mm = (beam_count < STORE_DEPTH) ? int'(prev_scan_range[beam_count]) : 0;
        case ($urandom_range(9))
            0: pick = -1;
            1: pick = $urandom_range(65535);
            2: pick = $urandom_range(1) ? 65535 : 0;
            3, 4:
            begin
                offset = int'(max_change) + int'($urandom_range(2)) - 1;
                pick = $urandom_range(1) ? stored_mm + offset : stored_mm - offset;
            end
            5: pick = $urandom_range(near_limit);
            6: pick = int'(near_limit) + int'($urandom_range(2)) - 1;
            default: pick = stored_mm + int'($urandom_range(40)) - 20;
        endcase
        if (pick < -1)
            pick = -1;
        if (pick > 65535)
            pick = 65535;
        return DIST_W'(pick);
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return LIMIT_W'($urandom_range(65535));
            default: return LIMIT_W'($urandom_range(1000));
        endcase
    endfunction

    // one reading transfer, then a random idle stretch
    task automatic send_reading(logic signed [DIST_W-1:0] reading, logic scan_end);
        beam_t expected_beam;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-DIST_W){1'b0}}, reading};
        s_axis_tlast  <= scan_end;
        do @(posedge clk); while (!s_axis_tready);
        expected_beam = filter_reading(reading, scan_end);
        pending_beams.insert(pending_beams.size(), expected_beam);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic send_scan(int length);
        for (int i = 0; i < length; i++)
            send_reading(pick_range(), i == length - 1);
    endtask

    // stop sending and wait for every pending beam
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_beams.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all four registers while the block is idle
    task automatic apply_settings(logic enable, logic [LIMIT_W-1:0] near_mm,
                                  logic [LIMIT_W-1:0] change_mm,
                                  logic signed [START_W-1:0] angle);
        drain_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FILTER_ENABLE;
        cfg_data  <= CFG_DATA_W'(enable);
        @(posedge clk);
        cfg_index <= REG_NEAR_RANGE;
        cfg_data  <= near_mm;
        @(posedge clk);
        cfg_index <= REG_MAX_DIFFERENCE;
        cfg_data  <= change_mm;
        @(posedge clk);
        cfg_index <= REG_START_ANGLE;
        cfg_data  <= CFG_DATA_W'(angle);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        filter_on   = enable;
        near_limit  = near_mm;
        max_change  = change_mm;
        first_angle = angle;
    endtask

    task automatic apply_random_settings();
        logic signed [START_W-1:0] angle;
        case ($urandom_range(3))
            0: angle = -10'sd512;
            1: angle = 10'sd511;
            default: angle = START_W'($urandom);
        endcase
        apply_settings($urandom_range(3) != 0, pick_limit(), pick_limit(), angle);
    endtask

    // first scan after reset with reset registers: never filtered, and longer than
    // any later scan so that every later beam finds a stored reading
    task automatic test_first_scan();
        sender_idle_pct    = 14;
        receiver_stall_pct = 14;
        send_scan(128);
    endtask

    // thresholds around near limit 500 and change 100, no return, range extremes
    task automatic test_glint_rules();
        int seed_scan[12]  = '{300, 300, 300, 300, 300, 300, 300, 300, -1, 65535, 0, 300};
        int probe_scan[12] = '{401, 400, 199, -1, 500, 499, 65535, 0, 99, 0, 300, 400};
        for (int i = 0; i < 12; i++)
            send_reading(DIST_W'(seed_scan[i]), i == 11);
        for (int i = 0; i < 12; i++)
            send_reading(DIST_W'(probe_scan[i]), i == 11);
        // scan of a single reading
        send_reading(pick_range(), 1'b1);
    endtask

    task automatic test_register_extremes();
        // filter off still refreshes the store
        apply_settings(1'b0, NEAR_RANGE_RST, MAX_DIFF_RST, START_ANGLE_RST);
        send_scan(20);
        apply_settings(1'b1, NEAR_RANGE_RST, MAX_DIFF_RST, START_ANGLE_RST);
        send_scan(20);
        // only no-return readings fall below a zero limit
        apply_settings(1'b1, '0, '0, -10'sd512);
        send_scan(16);
        // widest limit, highest start angle
        apply_settings(1'b1, '1, '0, 10'sd511);
        send_scan(80);
        apply_settings(1'b1, '1, '1, '0);
        send_scan(16);
    endtask

    // long receiver hold while the sender keeps offering readings
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_toggle <= ~hold_off_toggle;
        send_scan(60);
        drain_pipeline();
    endtask

    task automatic test_random_scans();
        int idle_pct[4]  = '{0, 82, 0, 14};
        int stall_pct[4] = '{0, 0, 82, 14};
        int sent;
        int length;
        for (int phase = 0; phase < 4; phase++)
        begin
            apply_random_settings();
            sender_idle_pct    = idle_pct[phase];
            receiver_stall_pct = stall_pct[phase];
            sent = 0;
            while (sent < 110)
            begin
                length = ($urandom_range(9) == 0) ? $urandom_range(49, 120)
                                                  : $urandom_range(1, 24);
                send_scan(length);
                sent += length;
                if ($urandom_range(7) == 0)
                    apply_random_settings();
            end
        end
    endtask

    // receiver: random stalls, or a counted hold-off when requested
    always @(posedge clk)
    begin
        if (hold_off_toggle != hold_off_seen)
        begin
            hold_off_seen <= hold_off_toggle;
            hold_off_left <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic note_mismatch(string field, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    endtask

    // compare each output transfer with the oldest pending beam
    always @(posedge clk)
    begin : check_beams
        beam_t got_beam;
        beam_t want_beam;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_beam.range_mm = m_axis_tdata[DIST_W-1:0];
            got_beam.angle    = m_axis_tdata[DIST_W +: ANGLE_W];
            got_beam.index    = m_axis_tdata[DIST_W+ANGLE_W +: INDEX_W];
            got_beam.last     = m_axis_tlast;
            if (pending_beams.size() == 0)
            begin
                note_mismatch("unexpected transfer, filtered_distance", 0, got_beam.range_mm);
            end
            else
            begin
                want_beam = pending_beams.pop_front();
                if (got_beam.range_mm !== want_beam.range_mm)
                    note_mismatch("filtered_distance", want_beam.range_mm, got_beam.range_mm);
                if (got_beam.angle !== want_beam.angle)
                    note_mismatch("beam_angle", want_beam.angle, got_beam.angle);
                if (got_beam.index !== want_beam.index)
                    note_mismatch("beam_index", want_beam.index, got_beam.index);
                if (got_beam.last !== want_beam.last)
                    note_mismatch("last", want_beam.last, got_beam.last);
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_scan();
        test_glint_rules();
        test_register_extremes();
        test_backpressure();
        test_random_scans();
        drain_pipeline();
        if (mismatch_count == 0)
            $display("range_scan_temporal_filter_test: PASS");
        else
            $display("range_scan_temporal_filter_test: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("range_scan_temporal_filter_test: FAIL");
        $finish;
    end

endmodule
